@@ design/slir_pkg.sv @@
package slir_pkg;

   // Default sizing of the store
   localparam int CapacityDefault = 16;
   localparam int ItemBitsDefault = 32;

   // Fixed field widths of the channels
   localparam int ValueBits    = 32;
   localparam int PositionBits = 4;
   localparam int CountBits    = 5;
   localparam int ReqDataBits  = 40;
   localparam int RspDataBits  = 40;

   // Operation codes carried on req_tuser
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // Per-cycle update strobes broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } ctrl_type;

   // One result item
   typedef struct packed {
      logic [ValueBits-1:0] read_value;
      logic [CountBits-1:0] entry_count;
      status_type           status;
   } result_type;

endpackage

@@ design/slir_cell.sv @@
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast item and takes its own, its left or its right neighbor's
// entry on an update.
module slir_cell #(
   parameter int ITEM_BITS = slir_pkg::ItemBitsDefault
) (
   input  logic                        clock,
   input  slir_pkg::ctrl_type          ctrl,
   input  logic signed [ITEM_BITS-1:0] item,
   input  logic                        valid,
   input  logic                        prev_lt,
   input  logic signed [ITEM_BITS-1:0] left_entry,
   input  logic signed [ITEM_BITS-1:0] right_entry,
   output logic signed [ITEM_BITS-1:0] entry,
   output logic                        lt,
   output logic                        hit
);

   logic signed [ITEM_BITS-1:0] entry_ff;
   logic signed [ITEM_BITS-1:0] entry_in;

   // Stored value is below the item; true over a prefix of the chain
   assign lt  = valid && (entry_ff < item);
   // First slot not below the item, and equal to it
   assign hit = prev_lt && !lt && valid && (entry_ff == item);

   // Insert: shift right from the insertion slot; remove: shift left
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && !lt) begin
         entry_in = prev_lt ? item : left_entry;
      end else if (ctrl.rem && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ design/slir_skid.sv @@
// Output register with one skid entry, so an item can be accepted while a
// result is still waiting to be taken.
module slir_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  slir_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output slir_pkg::result_type out_data
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   slir_pkg::result_type out_data_ff;
   slir_pkg::result_type out_data_in;
   slir_pkg::result_type skid_data_ff;
   slir_pkg::result_type skid_data_in;

   assign in_ready = !skid_valid_ff;

   // Refill the output from the skid first, else from the new item
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ design/sorted_list_insert_remove_core.sv @@
// Sorted store of up to CAPACITY signed values, kept in ascending order.
// Input channel req_*: req_tuser is the operation (insert, remove, read),
// req_tdata carries the value and the read position. Result channel rsp_*:
// one result per item with status, entry count after the operation and,
// for a read, the entry at the position (zero otherwise).
// An insert lands in front of the first stored value that is greater or
// equal; a remove deletes the first equal value or reports not found; an
// insert into a full store is dropped and flagged.
// The store is a chain of cells, one per entry; every cell compares its
// entry with the item in parallel and takes its own or a neighbor's entry.
// The result is registered in the output stage, or in the skid entry
// while the result side stalls.
// One item per cycle is accepted while the result side keeps up; a stalled
// result side still lets one more item in (skid entry), then req_tready
// drops until results are taken.
// Reset (synchronous, active high) empties the store; entries are not
// cleared, only the count.
module sorted_list_insert_remove_core #(
   parameter int CAPACITY  = slir_pkg::CapacityDefault,
   parameter int ITEM_BITS = slir_pkg::ItemBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [1:0]                       req_tuser, // [1:0] cmd
   // [31:0] value, [35:32] position, [39:36] zero
   input  logic [slir_pkg::ReqDataBits-1:0] req_tdata,
   // Result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [6:2] entry_count, [38:7] read_value, [39] zero
   output logic [slir_pkg::RspDataBits-1:0] rsp_tdata
);

   localparam int CountW = $clog2(CAPACITY + 1);

   logic                                 accept;
   slir_pkg::cmd_type                    cmd;
   logic signed [slir_pkg::ValueBits-1:0] value_s;
   logic [slir_pkg::PositionBits-1:0]    position;
   logic signed [ITEM_BITS-1:0]          item;

   logic [CountW-1:0]                    count_ff;
   logic [CountW-1:0]                    count_in;
   logic                                 full;
   logic                                 found;
   slir_pkg::ctrl_type                   ctrl;

   logic signed [ITEM_BITS-1:0]          entry_w [CAPACITY];
   logic [CAPACITY-1:0]                  lt_w;
   logic [CAPACITY-1:0]                  hit_w;
   logic [CAPACITY-1:0]                  valid_w;

   logic signed [ITEM_BITS-1:0]          rd_raw;
   logic                                 rd_hit;
   slir_pkg::result_type                 result;
   slir_pkg::result_type                 rsp_data;
   logic                                 skid_ready;

   // Unpack the input item
   assign cmd      = slir_pkg::cmd_type'(req_tuser);
   assign value_s  = req_tdata[slir_pkg::ValueBits-1:0];
   assign position = req_tdata[slir_pkg::ValueBits +: slir_pkg::PositionBits];
   assign item     = ITEM_BITS'(value_s);

   assign req_tready = skid_ready;
   assign accept     = req_tvalid && skid_ready;

   assign full  = (count_ff == CountW'(CAPACITY));
   assign found = |hit_w;

   // Update strobes for the chain
   always_comb begin
      ctrl.ins = accept && (cmd == slir_pkg::CMD_INSERT) && !full;
      ctrl.rem = accept && (cmd == slir_pkg::CMD_REMOVE) && found;
   end

   // Chain of cells, each handing entries to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                        prev_lt;
      logic signed [ITEM_BITS-1:0] left_entry;
      logic signed [ITEM_BITS-1:0] right_entry;

      assign valid_w[i] = (count_ff > CountW'(i));

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign left_entry = item;
      end else begin : g_inner
         assign prev_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_body
         assign right_entry = entry_w[i+1];
      end

      slir_cell #(
         .ITEM_BITS(ITEM_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .item       (item),
         .valid      (valid_w[i]),
         .prev_lt    (prev_lt),
         .left_entry (left_entry),
         .right_entry(right_entry),
         .entry      (entry_w[i]),
         .lt         (lt_w[i]),
         .hit        (hit_w[i])
      );
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CountW'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Read select over the valid cells
   always_comb begin
      rd_raw = '0;
      rd_hit = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if ((32'(position) == 32'(i)) && valid_w[i]) begin
            rd_raw = entry_w[i];
            rd_hit = 1'b1;
         end
      end
   end

   // Result of the accepted item
   always_comb begin
      result.status      = slir_pkg::ST_OK;
      result.entry_count = slir_pkg::CountBits'(count_in);
      result.read_value  = '0;
      case (cmd)
         slir_pkg::CMD_INSERT: begin
            if (full) begin
               result.status = slir_pkg::ST_FULL;
            end
         end
         slir_pkg::CMD_REMOVE: begin
            if (!found) begin
               result.status = slir_pkg::ST_NOT_FOUND;
            end
         end
         slir_pkg::CMD_READ: begin
            if (rd_hit) begin
               result.read_value = slir_pkg::ValueBits'(rd_raw);
            end else begin
               result.status = slir_pkg::ST_RANGE;
            end
         end
         default: begin
            result.status = slir_pkg::ST_OK;
         end
      endcase
   end

   // Output register and skid
   slir_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_ready (skid_ready),
      .in_data  (result),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_data)
   );

   assign rsp_tdata = slir_pkg::RspDataBits'(rsp_data);

endmodule

@@ test/tb_sorted_list_insert_remove_core.sv @@
`timescale 1ns / 1ps

module tb_sorted_list_insert_remove_core;

   localparam int Capacity   = slir_pkg::CapacityDefault;
   localparam int CycleLimit = 400000;
   localparam int HoldCycles = 60;
   localparam int SegmentLen = 60;
   // cmd code with no operation behind it
   localparam logic [1:0] CmdUnused = 2'd3;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [1:0]                       req_tuser  = '0;  // [1:0] cmd
   // [31:0] value, [35:32] position, [39:36] zero
   logic [slir_pkg::ReqDataBits-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [1:0] status, [6:2] entry_count, [38:7] read_value, [39] zero
   logic [slir_pkg::RspDataBits-1:0] rsp_tdata;

   // shadow copy of the sorted store
   logic signed [31:0]   sorted_shadow [Capacity];
   int                   shadow_fill = 0;
   slir_pkg::result_type expected_outcomes [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit no_idle        = 1'b0;
   bit hold_pending   = 1'b0;

   sorted_list_insert_remove_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_sorted_list_insert_remove_core: FAIL");
         $finish;
      end
   end

   // Apply one operation to the shadow store and return its result
   function automatic slir_pkg::result_type apply_list_op(input logic [1:0] op,
                                                input logic signed [31:0] val,
                                                input logic [3:0] pos);
      slir_pkg::result_type r;
      int                   idx;
      int                   k;
      r.status     = slir_pkg::ST_OK;
      r.read_value = '0;
      idx          = 0;
      case (op)
         slir_pkg::CMD_INSERT: begin
            if (shadow_fill >= Capacity) begin
               r.status = slir_pkg::ST_FULL;
            end else begin
               // lands in front of the first entry >= val
               while (idx < shadow_fill && sorted_shadow[idx] < val) idx++;
               for (k = shadow_fill; k > idx; k--) sorted_shadow[k] = sorted_shadow[k-1];
               sorted_shadow[idx] = val;
               shadow_fill++;
            end
         end
         slir_pkg::CMD_REMOVE: begin
            while (idx < shadow_fill && sorted_shadow[idx] < val) idx++;
            if (idx < shadow_fill && sorted_shadow[idx] == val) begin
               for (k = idx; k < shadow_fill - 1; k++) sorted_shadow[k] = sorted_shadow[k+1];
               shadow_fill--;
            end else begin
               r.status = slir_pkg::ST_NOT_FOUND;
            end
         end
         slir_pkg::CMD_READ: begin
            if (int'(pos) < shadow_fill) r.read_value = sorted_shadow[pos];
            else r.status = slir_pkg::ST_RANGE;
         end
         default: ;
      endcase
      r.entry_count = shadow_fill[slir_pkg::CountBits-1:0];
      return r;
   endfunction

   // Offer one item, wait for accept, record what it should produce
   task automatic push_list_op(input logic [1:0] op, input logic [31:0] val,
                               input logic [3:0] pos);
      int gap;
      gap = 0;
      if (!no_idle) while ($urandom_range(99) < 37) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, pos, val};
      do @(posedge clock); while (!req_tready);
      expected_outcomes.push_back(apply_list_op(op, val, pos));
   endtask

   // Stop offering and let every outstanding result come back
   task automatic wait_for_outcomes();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // Values: often a narrow band or a stored entry, so duplicates and remove hits are common
   function automatic logic [31:0] pick_value(input bit for_remove);
      int sel;
      sel = $urandom_range(99);
      if (for_remove && shadow_fill > 0 && $urandom_range(99) < 65)
         return sorted_shadow[$urandom_range(shadow_fill - 1)];
      if (sel < 45) return 32'(int'($urandom_range(16)) - 8);
      if (sel < 55) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0001;
            default: return 32'h7FFF_FFFE;
         endcase
      end
      return $urandom;
   endfunction

   // One random item; fill_bias leans toward inserts, else toward removes
   task automatic push_random_op(input bit fill_bias);
      int          sel;
      logic [3:0]  pos;
      sel = $urandom_range(99);
      if (shadow_fill > 0 && $urandom_range(99) < 80) pos = 4'($urandom_range(shadow_fill - 1));
      else pos = 4'($urandom_range(15));
      if (sel < (fill_bias ? 55 : 20))
         push_list_op(slir_pkg::CMD_INSERT, pick_value(1'b0), pos);
      else if (sel < 75)
         push_list_op(slir_pkg::CMD_REMOVE, pick_value(1'b1), pos);
      else if (sel < 95)
         push_list_op(slir_pkg::CMD_READ, pick_value(1'b0), pos);
      else
         push_list_op(CmdUnused, pick_value(1'b0), pos);
   endtask

   // Result side: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 37);
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      slir_pkg::result_type want;
      slir_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(slir_pkg::result_type)-1:0];
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual %0h", $time, got);
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            check_field("read_value", want.read_value, got.read_value);
         end
      end
   end

   // Empty store: read past end, remove miss, unused command
   task automatic test_empty_store();
      push_list_op(slir_pkg::CMD_READ, 32'h0, 4'd0);
      push_list_op(slir_pkg::CMD_REMOVE, 32'd5, 4'd0);
      push_list_op(CmdUnused, 32'hFFFF_FFFF, 4'hF);
   endtask

   // Extreme values, equal values, reads at both ends and past end
   task automatic test_extremes();
      push_list_op(slir_pkg::CMD_INSERT, 32'h7FFF_FFFF, 4'd0);
      push_list_op(slir_pkg::CMD_INSERT, 32'h8000_0000, 4'hF);
      push_list_op(slir_pkg::CMD_INSERT, 32'h0, 4'd0);
      push_list_op(slir_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
      push_list_op(slir_pkg::CMD_INSERT, 32'h0, 4'd0);
      push_list_op(slir_pkg::CMD_READ, 32'h0, 4'd0);
      push_list_op(slir_pkg::CMD_READ, 32'h0, 4'd4);
      push_list_op(slir_pkg::CMD_READ, 32'h0, 4'hF);
      push_list_op(slir_pkg::CMD_REMOVE, 32'h0, 4'd0);
      push_list_op(slir_pkg::CMD_REMOVE, 32'd7, 4'd0);
   endtask

   // Fill to capacity, then one insert too many and a read of the last slot
   task automatic test_full_store();
      while (shadow_fill < Capacity)
         push_list_op(slir_pkg::CMD_INSERT, $urandom, 4'($urandom_range(15)));
      push_list_op(slir_pkg::CMD_INSERT, 32'd1, 4'd0);
      push_list_op(slir_pkg::CMD_READ, 32'h0, 4'hF);
   endtask

   // Back-to-back items with the result side always ready
   task automatic test_streaming(input int count);
      no_idle = 1'b1;
      for (int n = 0; n < count; n++) push_random_op(n[6]);
      wait_for_outcomes();
      no_idle = 1'b0;
   endtask

   // Result side holds off while the sender keeps offering
   task automatic test_backpressure(input int count);
      wait_for_outcomes();
      no_idle      = 1'b1;
      hold_pending = 1'b1;
      for (int n = 0; n < count; n++) push_random_op(1'b1);
      wait_for_outcomes();
      no_idle = 1'b0;
   endtask

   // Random mix in segments that alternately grow and shrink the store
   task automatic test_random_mix(input int count);
      bit fill_bias;
      fill_bias = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % SegmentLen == 0) fill_bias = ~fill_bias;
         push_random_op(fill_bias);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_extremes();
      test_full_store();
      test_random_mix(700);
      test_backpressure(40);
      test_streaming(200);
      test_random_mix(710);
      wait_for_outcomes();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_sorted_list_insert_remove_core: PASS");
      end else begin
         $display("tb_sorted_list_insert_remove_core: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/slir_pkg.sv
design/slir_cell.sv
design/slir_skid.sv
design/sorted_list_insert_remove_core.sv
test/tb_sorted_list_insert_remove_core.sv
